### sv/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SLWDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLWDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/slwdt_pkg.sv
// Package: types, codes and constants of the loop watchdog timer.
`timescale 1ns / 1ps
`default_nettype none
package slwdt_pkg;

   localparam int PERIOD_W  = 32;
   localparam int TIME_W    = 48;
   localparam int SKIP_W    = 8;
   localparam int MS_W      = 23;
   localparam int MODE_W    = 3;
   localparam int CODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_MIN_US_DEF     = 32'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX_US_DEF     = 32'd10000000;
   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_US_DEF = 32'd10000;

   // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
   localparam int RECIP_SHIFT = 42;
   localparam int PROD_W      = 65;
   localparam logic [PROD_W-1:0] RECIP_1000 = 65'd4398046512;
   localparam logic [PERIOD_W-1:0] US_PER_MS = 32'd1000;

   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CYCLE_END  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_START      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STOP       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_PERIOD = 3'd4;

   localparam logic [CODE_W-1:0] RC_OK      = 2'd0;
   localparam logic [CODE_W-1:0] RC_INVALID = 2'd1;
   localparam logic [CODE_W-1:0] RC_CLAMPED = 2'd2;

   localparam logic [STATUS_W-1:0] ST_CREATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_HALTED  = 2'd3;

   localparam logic REG_MAX_SKIP  = 1'b0;
   localparam logic REG_WD_ENABLE = 1'b1;

   localparam logic [SKIP_W-1:0] MAX_SKIP_RESET = 8'd2;
   localparam logic [SKIP_W-1:0] SKIP_SAT       = 8'd255;

   typedef struct packed {
      logic [SKIP_W-1:0] max_skipped_loops;
      logic              watchdog_enable;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic clamped;
   } period_status_type;

endpackage
`default_nettype wire

### sv/slwdt_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module slwdt_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [slwdt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [slwdt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [slwdt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output slwdt_pkg::cfg_type                cfg
);
   import slwdt_pkg::*;

   logic [SKIP_W-1:0] max_skip_ff;
   logic              wd_en_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_skip_ff <= MAX_SKIP_RESET;
         wd_en_ff    <= 1'b1;
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_MAX_SKIP) begin
            max_skip_ff <= csr_pwdata[SKIP_W-1:0];
         end else begin
            wd_en_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_WD_ENABLE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, wd_en_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W-SKIP_W){1'b0}}, max_skip_ff};
      end
   end

   assign cfg.max_skipped_loops = max_skip_ff;
   assign cfg.watchdog_enable   = wd_en_ff;

endmodule
`default_nettype wire

### sv/slwdt_period.sv
// Period register with clamping and the millisecond step derived from it.
`timescale 1ns / 1ps
`default_nettype none
module slwdt_period #(
   parameter logic [31:0] PERIOD_MIN_US     = slwdt_pkg::PERIOD_MIN_US_DEF,
   parameter logic [31:0] PERIOD_MAX_US     = slwdt_pkg::PERIOD_MAX_US_DEF,
   parameter logic [31:0] DEFAULT_PERIOD_US = slwdt_pkg::DEFAULT_PERIOD_US_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               load,
   input  wire [slwdt_pkg::PERIOD_W-1:0]     period_value,
   output slwdt_pkg::period_status_type      status,
   output logic [slwdt_pkg::MS_W-1:0]        period_ms
);
   import slwdt_pkg::*;

   localparam logic [PERIOD_W-1:0] DEFAULT_MS_FULL = DEFAULT_PERIOD_US / US_PER_MS;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic [MS_W-1:0]     ms_ff;
   logic                busy_ff;
   logic                clamped;
   logic [PROD_W-1:0]   prod;

   always_comb begin
      if (period_value > PERIOD_MAX_US) begin
         period_in = PERIOD_MAX_US;
         clamped   = 1'b1;
      end else if (period_value < PERIOD_MIN_US) begin
         period_in = PERIOD_MIN_US;
         clamped   = 1'b1;
      end else begin
         period_in = period_value;
         clamped   = 1'b0;
      end
   end

   assign prod = {{(PROD_W-PERIOD_W){1'b0}}, period_ff} * RECIP_1000;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= DEFAULT_PERIOD_US;
         ms_ff     <= DEFAULT_MS_FULL[MS_W-1:0];
         busy_ff   <= 1'b0;
      end else begin
         busy_ff <= load;
         if (load) begin
            period_ff <= period_in;
         end
         if (busy_ff) begin
            ms_ff <= prod[RECIP_SHIFT +: MS_W];
         end
      end
   end

   assign status.busy    = busy_ff;
   assign status.clamped = clamped;
   assign period_ms      = ms_ff;

endmodule
`default_nettype wire

### sv/slwdt_ctrl.sv
// Loop state, watchdog counters and the response register.
`timescale 1ns / 1ps
`default_nettype none
module slwdt_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [slwdt_pkg::MODE_W-1:0]       mode,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [slwdt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  slwdt_pkg::cfg_type                cfg,
   input  slwdt_pkg::period_status_type      pstat,
   input  wire [slwdt_pkg::MS_W-1:0]         period_ms,
   output logic                              period_load
);
   import slwdt_pkg::*;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in, skip_inc;
   logic                tripped_ff, tripped_in;
   logic                pending_ff, pending_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   iter_ff, iter_in;
   logic [CODE_W-1:0]   code;
   logic                start;
   logic                accept;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_tready  = (!rsp_valid_ff || rsp_tready) && !pstat.busy;
   assign accept      = req_tvalid && req_tready;
   assign period_load = accept && (mode == MODE_SET_PERIOD);
   assign skip_inc    = (skip_ff < SKIP_SAT) ? skip_ff + 1'b1 : skip_ff;

   always_comb begin
      status_in  = status_ff;
      skip_in    = skip_ff;
      tripped_in = tripped_ff;
      pending_in = pending_ff;
      time_in    = time_ff;
      iter_in    = iter_ff;
      code       = RC_OK;
      start      = 1'b0;
      case (mode)
         MODE_TICK: begin
            if (status_ff == ST_RUNNING) begin
               time_in = time_ff + {{(TIME_W-MS_W){1'b0}}, period_ms};
               if (pending_ff) begin
                  pending_in = 1'b0;
                  skip_in    = '0;
                  tripped_in = 1'b0;
                  iter_in    = iter_ff + 1'b1;
                  start      = 1'b1;
               end else if (cfg.watchdog_enable) begin
                  skip_in = skip_inc;
                  if (skip_inc > cfg.max_skipped_loops) begin
                     tripped_in = 1'b1;
                     status_in  = ST_HALTED;
                  end
               end
            end
         end
         MODE_CYCLE_END: begin
            pending_in = 1'b1;
         end
         MODE_START: begin
            if (status_ff == ST_RUNNING) begin
               code = RC_INVALID;
            end else begin
               if (status_ff == ST_HALTED) begin
                  tripped_in = 1'b0;
                  skip_in    = '0;
               end
               status_in  = ST_RUNNING;
               pending_in = 1'b0;
               start      = 1'b1;
            end
         end
         MODE_STOP: begin
            if (status_ff != ST_RUNNING) begin
               code = RC_INVALID;
            end else begin
               status_in = ST_STOPPED;
            end
         end
         MODE_SET_PERIOD: begin
            code = pstat.clamped ? RC_CLAMPED : RC_OK;
         end
         default: begin
            code = RC_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_CREATED;
         skip_ff      <= '0;
         tripped_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         time_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            status_ff    <= status_in;
            skip_ff      <= skip_in;
            tripped_ff   <= tripped_in;
            pending_ff   <= pending_in;
            time_ff      <= time_in;
            iter_ff      <= iter_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {2'b00, iter_in, time_in, tripped_in, status_in, start, code};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### sv/scan_loop_watchdog_timer_unit.sv
// Top level of the loop watchdog timer.
//
//  channel | direction | accepted when            | payload
//  req     | in        | req_tvalid & req_tready  | tuser: mode, tdata: period_value
//  rsp     | out       | rsp_tvalid & rsp_tready  | tdata: status fields, see port
//  csr     | in        | psel & penable & pwrite  | max_skipped_loops, watchdog_enable
//
//  One request per cycle while req_tready is high; its response is registered on acceptance.
//  A set period request holds req_tready low for the next cycle while the
//  millisecond step is recomputed by the reciprocal multiplier.
//  req_tready also drops while an unread response waits and rsp_tready is low.
//  Synchronous reset clears loop state and counters; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module scan_loop_watchdog_timer_unit #(
   parameter logic [31:0] PERIOD_MIN_US     = slwdt_pkg::PERIOD_MIN_US_DEF,
   parameter logic [31:0] PERIOD_MAX_US     = slwdt_pkg::PERIOD_MAX_US_DEF,
   parameter logic [31:0] DEFAULT_PERIOD_US = slwdt_pkg::DEFAULT_PERIOD_US_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // period_value[31:0]
   input  wire [slwdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[2:0]
   input  wire [slwdt_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // result_code[1:0], cycle_start[2], run_state[4:3], watchdog_tripped[5],
   // elapsed_ms[53:6], loop_count[101:54], zero[103:102]
   output logic [slwdt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [slwdt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [slwdt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [slwdt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import slwdt_pkg::*;

   cfg_type           cfg;
   period_status_type pstat;
   logic [MS_W-1:0]   period_ms;
   logic              period_load;

   slwdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   slwdt_period #(
      .PERIOD_MIN_US     (PERIOD_MIN_US),
      .PERIOD_MAX_US     (PERIOD_MAX_US),
      .DEFAULT_PERIOD_US (DEFAULT_PERIOD_US)
   ) u_period (
      .clock        (clock),
      .reset        (reset),
      .load         (period_load),
      .period_value (req_tdata),
      .status       (pstat),
      .period_ms    (period_ms)
   );

   slwdt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .mode        (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cfg         (cfg),
      .pstat       (pstat),
      .period_ms   (period_ms),
      .period_load (period_load)
   );

endmodule
`default_nettype wire

### sv/slwdt_checker.sv
// Port-level checker for the loop watchdog timer and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slwdt_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire [slwdt_pkg::MODE_W-1:0]       req_tuser,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire [slwdt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import slwdt_pkg::*;

   `SLWDT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   `SLWDT_ASSERT(a_set_gap, clock, reset, req_tvalid && req_tready && req_tuser == MODE_SET_PERIOD |=> !req_tready, "request taken right after set period")
   `SLWDT_ASSERT(a_start_running, clock, reset, rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[4:3] == ST_RUNNING && rsp_tdata[1:0] == RC_OK, "cycle start outside running")
   `SLWDT_ASSERT(a_trip_halted, clock, reset, rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[4:3] == ST_HALTED, "tripped flag without halt")

endmodule

bind scan_loop_watchdog_timer_unit slwdt_checker u_slwdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the loop overrun watchdog timer unit.
`timescale 1ns / 1ps
module tb;
   import slwdt_pkg::*;

   localparam logic [MODE_W-1:0] MODE_RESERVED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RESERVED_LAST  = 3'd7;

   typedef struct packed {
      logic [1:0]        zero_pad;
      logic [TIME_W-1:0] loop_count;
      logic [TIME_W-1:0] elapsed_ms;
      logic              watchdog_tripped;
      logic [1:0]        run_state;
      logic              cycle_start;
      logic [1:0]        result_code;
   } loop_report_t;

   class loop_watchdog_predictor;
      logic [SKIP_W-1:0]   max_skip;
      logic                wd_enable;
      logic [1:0]          status;
      logic [SKIP_W-1:0]   skips;
      logic                tripped;
      logic                end_pending;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   elapsed;
      logic [TIME_W-1:0]   loops;
      loop_report_t        expected_reports[$];
      int                  errors;
      int                  checked;

      function new();
         max_skip    = MAX_SKIP_RESET;
         wd_enable   = 1'b1;
         status      = ST_CREATED;
         skips       = '0;
         tripped     = 1'b0;
         end_pending = 1'b0;
         period      = DEFAULT_PERIOD_US_DEF;
         elapsed     = '0;
         loops       = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] value);
         loop_report_t w;
         w = '0;
         w.result_code = RC_OK;
         case (mode)
            MODE_TICK: begin
               if (status == ST_RUNNING) begin
                  elapsed = elapsed + {16'd0, period / US_PER_MS};
                  if (end_pending) begin
                     end_pending   = 1'b0;
                     skips         = '0;
                     tripped       = 1'b0;
                     loops         = loops + 1'b1;
                     w.cycle_start = 1'b1;
                  end else if (wd_enable) begin
                     if (skips != SKIP_SAT)
                        skips = skips + 1'b1;
                     if (skips > max_skip) begin
                        tripped = 1'b1;
                        status  = ST_HALTED;
                     end
                  end
               end
            end
            MODE_CYCLE_END: end_pending = 1'b1;
            MODE_START: begin
               if (status == ST_RUNNING) begin
                  w.result_code = RC_INVALID;
               end else begin
                  if (status == ST_HALTED) begin
                     tripped = 1'b0;
                     skips   = '0;
                  end
                  status        = ST_RUNNING;
                  end_pending   = 1'b0;
                  w.cycle_start = 1'b1;
               end
            end
            MODE_STOP: begin
               if (status != ST_RUNNING)
                  w.result_code = RC_INVALID;
               else
                  status = ST_STOPPED;
            end
            MODE_SET_PERIOD: begin
               if (value > PERIOD_MAX_US_DEF) begin
                  period        = PERIOD_MAX_US_DEF;
                  w.result_code = RC_CLAMPED;
               end else if (value < PERIOD_MIN_US_DEF) begin
                  period        = PERIOD_MIN_US_DEF;
                  w.result_code = RC_CLAMPED;
               end else begin
                  period = value;
               end
            end
            default: w.result_code = RC_INVALID;
         endcase
         w.run_state        = status;
         w.watchdog_tripped = tripped;
         w.elapsed_ms       = elapsed;
         w.loop_count       = loops;
         expected_reports.push_back(w);
      endfunction

      task report(string msg);
         $display("[%0t] response %0d: %s", $realtime, checked, msg);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         loop_report_t got;
         loop_report_t want;
         got = data;
         if (expected_reports.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = expected_reports.pop_front();
         if (got.result_code != want.result_code)
            report($sformatf("result_code %0d, want %0d", got.result_code, want.result_code));
         if (got.cycle_start != want.cycle_start)
            report($sformatf("cycle_start %0d, want %0d", got.cycle_start, want.cycle_start));
         if (got.run_state != want.run_state)
            report($sformatf("run_state %0d, want %0d", got.run_state, want.run_state));
         if (got.watchdog_tripped != want.watchdog_tripped)
            report($sformatf("watchdog_tripped %0d, want %0d",
                             got.watchdog_tripped, want.watchdog_tripped));
         if (got.elapsed_ms != want.elapsed_ms)
            report($sformatf("elapsed_ms %0d, want %0d", got.elapsed_ms, want.elapsed_ms));
         if (got.loop_count != want.loop_count)
            report($sformatf("loop_count %0d, want %0d", got.loop_count, want.loop_count));
         checked++;
      endtask
   endclass

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic [MODE_W-1:0]       req_tuser   = MODE_TICK;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   bit quiet = 1'b0;
   loop_watchdog_predictor book = new();

   scan_loop_watchdog_timer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(99, 0);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            book.check_response(rsp_tdata);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic send_request(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(mode, value);
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (book.expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic reg_index, logic [CSR_DATA_W-1:0] value);
      drain_requests();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_index == REG_MAX_SKIP)
         book.max_skip = value[SKIP_W-1:0];
      else
         book.wd_enable = value[0];
   endtask

   task automatic configure(logic [SKIP_W-1:0] max_skip, logic wd_enable);
      write_csr(REG_MAX_SKIP, {24'd0, max_skip});
      write_csr(REG_WD_ENABLE, {31'd0, wd_enable});
   endtask

   task automatic send_random_items(int count);
      int r;
      logic [MODE_W-1:0]   mode;
      logic [PERIOD_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0)
            quiet = ($urandom_range(3, 0) == 0);
         r = $urandom_range(99, 0);
         value = $urandom;
         if (r < 40) begin
            mode = MODE_TICK;
         end else if (r < 72) begin
            mode = MODE_CYCLE_END;
         end else if (r < 84) begin
            mode = MODE_START;
         end else if (r < 89) begin
            mode = MODE_STOP;
         end else if (r < 97) begin
            mode = MODE_SET_PERIOD;
            case ($urandom_range(4, 0))
               0: value = $urandom_range(PERIOD_MIN_US_DEF - 1, 0);
               1: value = $urandom_range(PERIOD_MAX_US_DEF, PERIOD_MIN_US_DEF);
               2: value = $urandom_range(32'hFFFF_FFFF, PERIOD_MAX_US_DEF + 1);
               3: value = $urandom_range(1, 0) ? PERIOD_MIN_US_DEF : PERIOD_MAX_US_DEF;
               default: value = $urandom;
            endcase
         end else begin
            mode = MODE_W'($urandom_range(MODE_RESERVED_LAST, MODE_RESERVED_FIRST));
         end
         send_request(mode, value);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(MODE_TICK, '0);
      send_request(MODE_STOP, '0);
      send_request(MODE_RESERVED_FIRST, 32'hFFFF_FFFF);
      send_request(MODE_RESERVED_FIRST + 3'd1, '0);
      send_request(MODE_RESERVED_LAST, 32'hFFFF_FFFF);
      send_request(MODE_SET_PERIOD, '0);
      send_request(MODE_SET_PERIOD, 32'hFFFF_FFFF);
      send_request(MODE_SET_PERIOD, PERIOD_MIN_US_DEF - 1);
      send_request(MODE_SET_PERIOD, PERIOD_MAX_US_DEF + 1);
      send_request(MODE_SET_PERIOD, PERIOD_MAX_US_DEF);
      send_request(MODE_SET_PERIOD, PERIOD_MIN_US_DEF);
      send_request(MODE_START, '0);
      send_request(MODE_START, '0);
      send_request(MODE_CYCLE_END, '0);
      send_request(MODE_CYCLE_END, '0);
      send_request(MODE_TICK, '0);
      repeat (3) send_request(MODE_TICK, '0);
      send_request(MODE_TICK, '0);
      send_request(MODE_START, '0);
      send_request(MODE_CYCLE_END, '0);
      send_request(MODE_STOP, '0);
      send_request(MODE_TICK, '0);
      send_request(MODE_START, '0);
      send_request(MODE_CYCLE_END, '0);
      send_request(MODE_TICK, '0);

      send_random_items(180);
      configure(8'd0, 1'b1);
      send_random_items(180);
      configure(SKIP_SAT, 1'b1);
      send_request(MODE_START, '0);
      repeat (300) send_request(MODE_TICK, $urandom);
      send_random_items(180);
      configure(8'd1, 1'b0);
      send_random_items(180);
      configure(SKIP_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      send_random_items(180);
      configure(8'd5, 1'b1);
      send_random_items(180);

      drain_requests();
      repeat (10) @(posedge clock);
      if (book.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
